>>> rtl/crspl_pkg.sv
// Package for the closed-loop Catmull-Rom spline evaluator.
// Payload structs, codes and fixed-point helpers; no dependencies.
`timescale 1ns / 1ps
package crspl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QDEPTH         = 2;
    localparam int TW             = 34;   // knot time with loop offset
    localparam int DIFFW          = 35;   // time differences
    localparam logic [31:0] W_LIMIT = 32'h4000_0000;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_LOAD_NEW = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZLEN  = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic              new_list;
        logic signed [31:0] time_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } crspl_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [1:0]         status;
    } crspl_out_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] time_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } crspl_entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/catmull_rom_loop_spline_eval_top.sv
// An evaluation uses the shared one-bit-per-cycle divider
// (one modulo plus five weights) and the serial knot scan over the table RAM;
// a load writes the table and answers without them.
// One item in the back end at a time; the next starts the cycle after the result
// transfer, and a 2-entry queue keeps taking transfers meanwhile.
// Reset (rst_n, async): empties the queue, clears point count and loop time.
`timescale 1ns / 1ps
module catmull_rom_loop_spline_eval_top #(
    parameter int MAX_POINTS = crspl_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = crspl_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  crspl_pkg::crspl_in_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output crspl_pkg::crspl_out_t rsp
);
    import crspl_pkg::*;

    logic         q_valid, q_pop;
    crspl_entry_t q_entry;

    crspl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry)
    );

    crspl_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule

>>> rtl/crspl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module crspl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/crspl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module crspl_div #(
    parameter int NW = 51,
    parameter int DW = 35
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [DW:0]     acc;
    logic            ge;

    always_comb
    begin
        acc      = {rem_reg, quo_reg[NW-1]};
        ge       = acc >= {1'b0, den_reg};
        rem_next = ge ? DW'(acc - {1'b0, den_reg}) : acc[DW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif
endmodule

>>> rtl/crspl_front.sv
// Front end: takes request transfers, classifies them and queues them.
// Depends on crspl_pkg.
`timescale 1ns / 1ps
module crspl_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  crspl_pkg::crspl_in_t    req,
    output logic                    q_valid,
    input  logic                    q_pop,
    output crspl_pkg::crspl_entry_t q_entry
);
    import crspl_pkg::*;

    crspl_entry_t mem_reg [QDEPTH];
    logic         wp_reg, rp_reg;
    logic [1:0]   count_reg;
    logic         push;
    crspl_entry_t ent;

    always_comb
    begin
        ent.op         = req.req_type ? OP_EVAL : (req.new_list ? OP_LOAD_NEW : OP_LOAD);
        ent.time_value = req.time_value;
        ent.point_x    = req.point_x;
        ent.point_y    = req.point_y;
        ent.point_z    = req.point_z;
    end

    assign req_ready = count_reg != 2'(QDEPTH);
    assign push      = req_valid && req_ready;
    assign q_valid   = count_reg != 2'd0;
    assign q_entry   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= ent;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("request queue overflow");
`endif
endmodule

>>> rtl/crspl_back.sv
// Back end: point table, loop time, segment search, weights and lerps.
// Depends on crspl_pkg, crspl_ram and crspl_div.
`timescale 1ns / 1ps
module crspl_back #(
    parameter int MAX_POINTS = crspl_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = crspl_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  crspl_pkg::crspl_entry_t q_entry,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output crspl_pkg::crspl_out_t   rsp
);
    import crspl_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int JW = CW + 2;
    localparam int NW = DIFFW + FRAC_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOD      = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CK  = 4'd3;
    localparam logic [3:0] S_FETCH_RD = 4'd4;
    localparam logic [3:0] S_FETCH_CK = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_WDIV_GO  = 4'd7;
    localparam logic [3:0] S_WDIV     = 4'd8;
    localparam logic [3:0] S_MUL      = 4'd9;
    localparam logic [3:0] S_ADD      = 4'd10;

    logic [3:0]         state_reg;
    logic [CW-1:0]      cnt_reg;
    logic [31:0]        loop_reg;
    logic               neg_reg;
    logic [31:0]        tq_reg;
    logic [CW-1:0]      scan_reg;
    logic [AW-1:0]      seg_reg;
    logic [1:0]         k_reg;
    logic signed [2:0]  off_reg;
    logic signed [TW-1:0] t_reg [4];
    logic signed [31:0] p_reg [4][3];
    logic signed [31:0] w_reg [5];
    logic [2:0]         wi_reg;
    logic               wneg_reg;
    logic [1:0]         c_reg;
    logic [2:0]         li_reg;
    logic signed [31:0] r_reg [5];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] a_reg;
    logic signed [64:0] prod_reg;
    logic               rsp_valid_reg;
    crspl_out_t         rsp_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [127:0]       ram_wdata, ram_rdata;
    logic               div_start, div_done;
    logic [NW-1:0]      div_num, div_quo;
    logic [DIFFW-1:0]   div_den, div_rem;

    crspl_ram #(.WIDTH(128), .DEPTH(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crspl_div #(.NW(NW), .DW(DIFFW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // load decode
    logic [CW-1:0]      cnt_eff;
    logic [31:0]        loop_eff;
    logic signed [33:0] loop_sum;
    logic [31:0]        tv_mag;
    // cyclic neighbor index
    logic [JW-1:0]      jj, j2, jsel, nn;
    logic signed [2:0]  off_sel;
    // weight setup
    logic [1:0]         ia, ib;
    logic signed [DIFFW-1:0] dnum, dden;
    logic [DIFFW-1:0]   dmag;
    logic [NW-1:0]      qclamp;
    logic signed [31:0] wval;
    // lerp operands
    logic signed [31:0] op_a, op_b, op_w;
    logic signed [32:0] bdiff;
    logic signed [65:0] rnd, lsum;
    logic signed [31:0] lres;
    logic signed [TW-1:0] knot_off, lx;
    logic [31:0]        rem32;

    always_comb
    begin
        cnt_eff  = (q_entry.op == OP_LOAD_NEW) ? '0 : cnt_reg;
        loop_eff = (q_entry.op == OP_LOAD_NEW) ? '0 : loop_reg;
        loop_sum = $signed({2'b00, loop_eff}) + 34'(q_entry.time_value);
        tv_mag   = q_entry.time_value[31] ? 32'(-q_entry.time_value) : q_entry.time_value;

        nn = JW'(cnt_reg);
        jj = JW'(seg_reg) + JW'(k_reg) - JW'(1);
        j2 = jj - nn;
        if (jj[JW-1])
        begin
            jsel    = jj + nn;
            off_sel = -3'sd1;
        end
        else if (jj >= nn)
        begin
            if (j2 >= nn)
            begin
                jsel    = j2 - nn;
                off_sel = 3'sd2;
            end
            else
            begin
                jsel    = j2;
                off_sel = 3'sd1;
            end
        end
        else
        begin
            jsel    = jj;
            off_sel = 3'sd0;
        end

        lx = TW'(loop_reg);
        case (off_reg)
            -3'sd1:  knot_off = -lx;
            3'sd1:   knot_off = lx;
            3'sd2:   knot_off = lx <<< 1;
            default: knot_off = '0;
        endcase

        case (wi_reg)
            3'd0:    begin ia = 2'd0; ib = 2'd1; end
            3'd1:    begin ia = 2'd1; ib = 2'd2; end
            3'd2:    begin ia = 2'd2; ib = 2'd3; end
            3'd3:    begin ia = 2'd0; ib = 2'd2; end
            default: begin ia = 2'd1; ib = 2'd3; end
        endcase
        dnum = DIFFW'(TW'(tq_reg)) - DIFFW'(t_reg[ia]);
        dden = DIFFW'(t_reg[ib]) - DIFFW'(t_reg[ia]);
        dmag = dnum[DIFFW-1] ? DIFFW'(-dnum) : DIFFW'(dnum);
        qclamp = (div_quo > NW'(W_LIMIT)) ? NW'(W_LIMIT) : div_quo;
        wval   = wneg_reg ? 32'(-qclamp[31:0]) : qclamp[31:0];

        case (li_reg)
            3'd0:    begin op_a = p_reg[0][c_reg]; op_b = p_reg[1][c_reg]; op_w = w_reg[0]; end
            3'd1:    begin op_a = p_reg[1][c_reg]; op_b = p_reg[2][c_reg]; op_w = w_reg[1]; end
            3'd2:    begin op_a = p_reg[2][c_reg]; op_b = p_reg[3][c_reg]; op_w = w_reg[2]; end
            3'd3:    begin op_a = r_reg[0]; op_b = r_reg[1]; op_w = w_reg[3]; end
            3'd4:    begin op_a = r_reg[1]; op_b = r_reg[2]; op_w = w_reg[4]; end
            default: begin op_a = r_reg[3]; op_b = r_reg[4]; op_w = w_reg[1]; end
        endcase
        bdiff = 33'(op_b) - 33'(op_a);
        rnd   = (66'(prod_reg) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        lsum  = 66'(a_reg) + rnd;
        lres  = sat32(lsum);
        rem32 = div_rem[31:0];
    end

    always_comb
    begin
        q_pop     = (state_reg == S_IDLE) && q_valid && !rsp_valid_reg;
        ram_we    = q_pop && (q_entry.op != OP_EVAL) && (cnt_eff < CW'(MAX_POINTS));
        ram_waddr = cnt_eff[AW-1:0];
        ram_wdata = {loop_eff, q_entry.point_x, q_entry.point_y, q_entry.point_z};
        ram_raddr = (state_reg == S_FETCH_RD) ? jsel[AW-1:0] : scan_reg[AW-1:0];
        div_start = 1'b0;
        div_num   = NW'(dmag) << FRAC_BITS;
        div_den   = dden;
        if (state_reg == S_IDLE)
        begin
            div_start = q_pop && (q_entry.op == OP_EVAL) && (cnt_reg != '0)
                        && (loop_reg != '0);
            div_num   = NW'(tv_mag);
            div_den   = DIFFW'(loop_reg);
        end
        else if (state_reg == S_WDIV_GO)
            div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            loop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_entry.op != OP_EVAL)
                        begin
                            rsp_valid_reg <= 1'b1;
                            cnt_reg       <= cnt_eff;
                            loop_reg      <= loop_eff;
                            if (ram_we)
                            begin
                                cnt_reg <= cnt_eff + 1'b1;
                                if (!q_entry.time_value[31])
                                    loop_reg <= loop_sum[31] ? 32'h7FFF_FFFF : loop_sum[31:0];
                            end
                        end
                        else if (!div_start)
                            rsp_valid_reg <= 1'b1;
                        else
                            state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                        state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD:
                    state_reg <= S_SCAN_CK;
                S_SCAN_CK:
                begin
                    if (ram_rdata[127:96] <= tq_reg && (scan_reg + 1'b1) < cnt_reg)
                        state_reg <= S_SCAN_RD;
                    else
                        state_reg <= S_FETCH_RD;
                end
                S_FETCH_RD:
                    state_reg <= S_FETCH_CK;
                S_FETCH_CK:
                    state_reg <= (k_reg == 2'd3) ? S_CHECK : S_FETCH_RD;
                S_CHECK:
                begin
                    if (t_reg[1] <= t_reg[0] || t_reg[2] <= t_reg[1] || t_reg[3] <= t_reg[2])
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_WDIV_GO;
                end
                S_WDIV_GO:
                    state_reg <= S_WDIV;
                S_WDIV:
                begin
                    if (div_done)
                        state_reg <= (wi_reg == 3'd4) ? S_MUL : S_WDIV_GO;
                end
                S_MUL:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    if (li_reg == 3'd5 && c_reg == 2'd2)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_MUL;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    neg_reg       <= q_entry.time_value[31];
                    scan_reg      <= '0;
                    seg_reg       <= '0;
                    rsp_reg.pos_x <= '0;
                    rsp_reg.pos_y <= '0;
                    rsp_reg.pos_z <= '0;
                    if (q_entry.op != OP_EVAL)
                        rsp_reg.status <= (cnt_eff < CW'(MAX_POINTS)) ? ST_OK : ST_FULL;
                    else
                        rsp_reg.status <= ST_EMPTY;
                end
            end
            S_MOD:
            begin
                rsp_reg.status <= ST_OK;
                tq_reg <= (neg_reg && rem32 != '0) ? loop_reg - rem32 : rem32;
            end
            S_SCAN_CK:
            begin
                k_reg <= 2'd0;
                if (ram_rdata[127:96] <= tq_reg)
                begin
                    seg_reg  <= scan_reg[AW-1:0];
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            S_FETCH_RD:
                off_reg <= off_sel;
            S_FETCH_CK:
            begin
                t_reg[k_reg]    <= TW'(ram_rdata[127:96]) + knot_off;
                p_reg[k_reg][0] <= ram_rdata[95:64];
                p_reg[k_reg][1] <= ram_rdata[63:32];
                p_reg[k_reg][2] <= ram_rdata[31:0];
                k_reg           <= k_reg + 1'b1;
            end
            S_CHECK:
            begin
                wi_reg <= 3'd0;
                if (t_reg[1] <= t_reg[0] || t_reg[2] <= t_reg[1] || t_reg[3] <= t_reg[2])
                    rsp_reg.status <= ST_ZLEN;
            end
            S_WDIV_GO:
                wneg_reg <= dnum[DIFFW-1];
            S_WDIV:
            begin
                if (div_done)
                begin
                    w_reg[wi_reg] <= wval;
                    wi_reg        <= wi_reg + 1'b1;
                    c_reg         <= 2'd0;
                    li_reg        <= 3'd0;
                end
            end
            S_MUL:
            begin
                a_reg    <= op_a;
                prod_reg <= 65'(bdiff) * 65'(op_w);
            end
            S_ADD:
            begin
                if (li_reg == 3'd5)
                begin
                    pos_reg[c_reg] <= lres;
                    li_reg         <= 3'd0;
                    c_reg          <= c_reg + 1'b1;
                    if (c_reg == 2'd2)
                    begin
                        rsp_reg.pos_x <= pos_reg[0];
                        rsp_reg.pos_y <= pos_reg[1];
                        rsp_reg.pos_z <= lres;
                    end
                end
                else
                begin
                    r_reg[li_reg] <= lres;
                    li_reg        <= li_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");
    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !rsp_valid_reg)
        else $error("result pending while an evaluation runs");
`endif
endmodule

>>> tb/sv/catmull_rom_loop_spline_eval_top_test.sv
// Self-checking testbench for catmull_rom_loop_spline_eval_top (closed-loop spline evaluator).
// Uses an in-bench fixed-point spline predictor and valid/ready driver and monitor blocks.
// Depends on crspl_pkg and the DUT RTL only.
`timescale 1ns / 1ps
module catmull_rom_loop_spline_eval_top_test;
    import crspl_pkg::*;

    localparam int  NPTS = 64;
    localparam int  FB = 16;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;
    localparam longint W_LIM = longint'(1) << 30;
    localparam int  CYCLE_LIMIT = 3000000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    crspl_in_t  req;
    logic       rsp_valid;
    logic       rsp_ready;
    crspl_out_t rsp;

    catmull_rom_loop_spline_eval_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predictor state
    longint knot_t [NPTS];
    longint cx [NPTS];
    longint cy [NPTS];
    longint cz [NPTS];
    int     pt_count = 0;
    longint loop_len = 0;

    crspl_in_t  pending_req_q [$];
    crspl_out_t expected_pos_q [$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  transfers_in = 0;
    int  mismatches = 0;
    int  cycles = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint knot_lerp(longint pa, longint pb, longint ta, longint tb,
                                         longint t);
        longint w;
        longint prod;
        w = ((t - ta) * (longint'(1) << FB)) / (tb - ta);
        if (w > W_LIM)
            w = W_LIM;
        if (w < -W_LIM)
            w = -W_LIM;
        prod = (pb - pa) * w + (longint'(1) << (FB - 1));
        return sat_q16(pa + (prod >>> FB));
    endfunction

    function automatic longint barry_goldman(longint p0, longint p1, longint p2, longint p3,
                                             longint t0, longint t1, longint t2, longint t3,
                                             longint tq);
        longint a1, a2, a3, b1, b2;
        a1 = knot_lerp(p0, p1, t0, t1, tq);
        a2 = knot_lerp(p1, p2, t1, t2, tq);
        a3 = knot_lerp(p2, p3, t2, t3, tq);
        b1 = knot_lerp(a1, a2, t0, t2, tq);
        b2 = knot_lerp(a2, a3, t1, t3, tq);
        return knot_lerp(b1, b2, t1, t2, tq);
    endfunction

    function automatic crspl_out_t spline_eval_step(crspl_in_t r);
        crspl_out_t o;
        longint tv, tq, off;
        longint t [4];
        int     idx [4];
        int     seg, j;
        o = '0;
        o.status = ST_OK;
        tv = longint'(r.time_value);
        if (r.req_type == REQ_LOAD)
        begin
            if (r.new_list)
            begin
                pt_count = 0;
                loop_len = 0;
            end
            if (pt_count >= NPTS)
                o.status = ST_FULL;
            else
            begin
                knot_t[pt_count] = loop_len;
                cx[pt_count] = longint'(r.point_x);
                cy[pt_count] = longint'(r.point_y);
                cz[pt_count] = longint'(r.point_z);
                pt_count++;
                if (tv > 0)
                    loop_len = sat_q16(loop_len + tv);
            end
        end
        else if (pt_count == 0 || loop_len <= 0)
            o.status = ST_EMPTY;
        else
        begin
            tq = tv % loop_len;
            if (tq < 0)
                tq += loop_len;
            seg = 0;
            while (seg < pt_count && knot_t[seg] <= tq)
                seg++;
            seg--;
            for (int k = 0; k < 4; k++)
            begin
                j = seg - 1 + k;
                off = 0;
                while (j < 0)
                begin
                    j += pt_count;
                    off -= loop_len;
                end
                while (j >= pt_count)
                begin
                    j -= pt_count;
                    off += loop_len;
                end
                t[k] = knot_t[j] + off;
                idx[k] = j;
            end
            if (t[1] - t[0] <= 0 || t[2] - t[1] <= 0 || t[3] - t[2] <= 0)
                o.status = ST_ZLEN;
            else
            begin
                o.pos_x = 32'(barry_goldman(cx[idx[0]], cx[idx[1]], cx[idx[2]], cx[idx[3]],
                                            t[0], t[1], t[2], t[3], tq));
                o.pos_y = 32'(barry_goldman(cy[idx[0]], cy[idx[1]], cy[idx[2]], cy[idx[3]],
                                            t[0], t[1], t[2], t[3], tq));
                o.pos_z = 32'(barry_goldman(cz[idx[0]], cz[idx[1]], cz[idx[2]], cz[idx[3]],
                                            t[0], t[1], t[2], t[3], tq));
            end
        end
        return o;
    endfunction

    function automatic crspl_in_t make_load(bit fresh, logic [31:0] dt, logic [31:0] x,
                                            logic [31:0] y, logic [31:0] z);
        crspl_in_t r;
        r.req_type = REQ_LOAD;
        r.new_list = fresh;
        r.time_value = dt;
        r.point_x = x;
        r.point_y = y;
        r.point_z = z;
        return r;
    endfunction

    function automatic crspl_in_t make_eval(logic [31:0] tq);
        crspl_in_t r;
        r = make_load(1'b0, tq, $urandom, $urandom, $urandom);
        r.req_type = REQ_EVAL;
        r.new_list = $urandom_range(1);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return $urandom | 32'h8000_0000;
            2: return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
            default: return $urandom_range(32'h0008_0000, 32'h0000_0100);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (req_valid)
                transfers_in++;
            if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= pending_req_q[0];
                expected_pos_q.push_back(spline_eval_step(pending_req_q[0]));
                void'(pending_req_q.pop_front());
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_pos_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %h", rsp);
                end
                else
                begin
                    if (rsp.pos_x !== expected_pos_q[0].pos_x
                        || rsp.pos_y !== expected_pos_q[0].pos_y
                        || rsp.pos_z !== expected_pos_q[0].pos_z
                        || rsp.status !== expected_pos_q[0].status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%h y=%h z=%h st=%0d ",
                                      "got x=%h y=%h z=%h st=%0d"},
                                     expected_pos_q[0].pos_x, expected_pos_q[0].pos_y,
                                     expected_pos_q[0].pos_z, expected_pos_q[0].status,
                                     rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.status);
                    end
                    void'(expected_pos_q.pop_front());
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int total;
        int n;
        send_idle_pct = 15;
        recv_idle_pct = 70;
        rst_n = 1'b0;

        // directed
        pending_req_q.push_back(make_eval(32'h0001_0000));
        pending_req_q.push_back(make_load(1'b1, 32'h0001_0000, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'h0000_0000));
        pending_req_q.push_back(make_eval(32'h0000_8000));
        pending_req_q.push_back(make_eval(32'h8000_0000));
        pending_req_q.push_back(make_load(1'b0, 32'hFFFF_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_req_q.push_back(make_eval(32'h0001_0000));
        pending_req_q.push_back(make_load(1'b0, 32'h0002_0000, 32'h0003_0000,
                                          32'hFFFE_0000, 32'h0001_8000));
        pending_req_q.push_back(make_eval(32'hFFFF_C000));
        pending_req_q.push_back(make_eval(32'h0003_0000));
        pending_req_q.push_back(make_eval(32'h7FFF_FFFF));
        pending_req_q.push_back(make_load(1'b1, 32'h0001_0000, 32'h0001_0000, 0, 0));
        pending_req_q.push_back(make_load(1'b0, 32'h0002_0000, 32'h0004_0000, 0, 0));
        pending_req_q.push_back(make_load(1'b0, 32'h0000_0000, 32'h0002_0000, 0, 0));
        pending_req_q.push_back(make_load(1'b0, 32'h0001_0000, 32'h0005_0000, 0, 0));
        pending_req_q.push_back(make_eval(32'h0001_8000));
        pending_req_q.push_back(make_eval(32'h0003_8000));
        pending_req_q.push_back(make_load(1'b1, 32'h7FFF_FFFF, 1, 2, 3));
        pending_req_q.push_back(make_load(1'b0, 32'h7FFF_FFFF, 4, 5, 6));
        pending_req_q.push_back(make_eval(32'h7FFF_FFFE));
        pending_req_q.push_back(make_load(1'b1, 32'h0000_0000, 7, 8, 9));
        pending_req_q.push_back(make_eval(32'h0000_0000));

        // random: fresh lists of points, then queries
        total = pending_req_q.size();
        while (total < 400)
        begin
            if ($urandom_range(9) == 0)
                n = $urandom_range(NPTS + 3, NPTS - 1);
            else
                n = $urandom_range(8, 1);
            pending_req_q.push_back(make_load(1'b1, rand_delta(), rand_coord(),
                                              rand_coord(), rand_coord()));
            for (int i = 1; i < n; i++)
                pending_req_q.push_back(make_load($urandom_range(40) == 0, rand_delta(),
                                                  rand_coord(), rand_coord(), rand_coord()));
            if (n >= NPTS)
                pending_req_q.push_back(make_load(1'b1, rand_delta(), rand_coord(),
                                                  rand_coord(), rand_coord()));
            total += n + (n >= NPTS ? 1 : 0);
            n = $urandom_range(10, 3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(3) == 0)
                    pending_req_q.push_back(make_eval($urandom));
                else
                    pending_req_q.push_back(make_eval(
                        32'($signed($urandom_range(32'h0030_0000)) - 32'sh0010_0000)));
            end
            total += n;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (transfers_in < total / 3)
            @(posedge clk);
        send_idle_pct = 70;
        recv_idle_pct = 15;
        while (transfers_in < 2 * total / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_req_q.size() > 0 || req_valid)
            @(posedge clk);
        while (expected_pos_q.size() > 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && expected_pos_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
rtl/crspl_pkg.sv
rtl/crspl_ram.sv
rtl/crspl_div.sv
rtl/crspl_front.sv
rtl/crspl_back.sv
rtl/catmull_rom_loop_spline_eval_top.sv
tb/sv/catmull_rom_loop_spline_eval_top_test.sv
